>>> rtl/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Types, sizes and helpers shared by the circular deque checker.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ELEM_W   = 31;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 11;

    localparam logic signed [VALUE_W-1:0] EXPECT_EMPTY = -32'sd1;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_POP_FRONT  = 2'd1,
        MODE_PUSH_BACK  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_t;

    typedef struct packed {
        logic [ELEM_W-1:0] popped_value;
        logic              was_empty;
        logic              overflow;
        logic              match;
        logic              verdict_ok;
        logic [OCC_W-1:0]  occupancy;
        logic              batch_done;
    } out_t;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = idx + IDX_W'(1);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == '0) begin
            r = IDX_W'(CAPACITY - 1);
        end else begin
            r = idx - IDX_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 31
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> rtl/circular_deque_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_checker_core
// Double-ended queue checker on a circular slot memory.
// ----------------------------------------------------------------------------
// A command is taken in ST_IDLE: in the transfer cycle the pointers move and
// the slot memory is written (push) or read (pop). In ST_RESULT the
// registered read data is compared with the expected value and the result is
// loaded into the output register once that register is free. The registered
// read port of the single slot memory sets this order: no new command is
// taken until the last result is loaded. A push to a full deque is
// dropped and reported as overflow; a command marked last clears the deque
// and the verdict after its result is formed. No clearing pass runs after
// reset: slots are only read after they have been written.
module circular_deque_checker_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cdq_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cdq_pkg::out_t      m_data
);

    cdq_pkg::state_t state_reg, state_next;

    logic [cdq_pkg::IDX_W-1:0] front_reg, front_next;
    logic [cdq_pkg::IDX_W-1:0] back_reg, back_next;
    logic [cdq_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      verdict_reg, verdict_next;

    // Command held between the transfer cycle and the result cycle.
    logic                               hit_reg, hit_next;
    logic                               empty_reg, empty_next;
    logic                               ovf_reg, ovf_next;
    logic                               last_reg, last_next;
    logic signed [cdq_pkg::VALUE_W-1:0] value_reg, value_next;

    // The read address stays on the popped slot while the result waits.
    logic [cdq_pkg::IDX_W-1:0] addr_reg, addr_next;

    logic           m_valid_reg, m_valid_next;
    cdq_pkg::out_t  m_data_reg, m_data_next;

    logic                       ram_we;
    logic [cdq_pkg::IDX_W-1:0]  ram_addr;
    logic [cdq_pkg::ELEM_W-1:0] ram_rdata;

    logic accept;
    logic load;
    logic is_full;
    logic is_empty;
    logic cur_match;
    logic cur_verdict;
    logic [cdq_pkg::ELEM_W-1:0] cur_popped;

    cdq_ram #(
        .DEPTH (cdq_pkg::CAPACITY),
        .WIDTH (cdq_pkg::ELEM_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data.value[cdq_pkg::ELEM_W-1:0]),
        .rdata (ram_rdata)
    );

    assign accept   = s_valid && s_ready;
    assign load     = (state_reg == cdq_pkg::ST_RESULT) && (!m_valid_reg || m_ready);
    assign is_full  = (count_reg == cdq_pkg::CNT_W'(cdq_pkg::CAPACITY));
    assign is_empty = (count_reg == '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = cdq_pkg::ST_RESULT;
                end
            end
            cdq_pkg::ST_RESULT: begin
                if (load) begin
                    state_next = cdq_pkg::ST_IDLE;
                end
            end
            default: state_next = cdq_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        case (state_reg)
            cdq_pkg::ST_IDLE:   s_ready = 1'b1;
            cdq_pkg::ST_RESULT: s_ready = 1'b0;
            default:            s_ready = 1'b0;
        endcase
    end

    // Result of the held command, formed from the registered read data.
    always_comb begin
        cur_popped = hit_reg ? ram_rdata : '0;
        if (hit_reg) begin
            cur_match = ($unsigned(value_reg) == {1'b0, ram_rdata});
        end else if (empty_reg) begin
            cur_match = (value_reg == cdq_pkg::EXPECT_EMPTY);
        end else begin
            cur_match = 1'b1;
        end
        cur_verdict = verdict_reg && cur_match && !ovf_reg;
    end

    always_comb begin
        front_next   = front_reg;
        back_next    = back_reg;
        count_next   = count_reg;
        verdict_next = verdict_reg;
        hit_next     = hit_reg;
        empty_next   = empty_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        value_next   = value_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_addr     = addr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            hit_next   = 1'b0;
            empty_next = 1'b0;
            ovf_next   = 1'b0;
            last_next  = s_data.last;
            value_next = s_data.value;
            case (s_data.mode)
                cdq_pkg::MODE_PUSH_FRONT: begin
                    if (is_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        front_next = cdq_pkg::prev_slot(front_reg);
                        ram_addr   = cdq_pkg::prev_slot(front_reg);
                        ram_we     = 1'b1;
                        count_next = count_reg + cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::MODE_PUSH_BACK: begin
                    if (is_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        ram_addr   = back_reg;
                        back_next  = cdq_pkg::next_slot(back_reg);
                        ram_we     = 1'b1;
                        count_next = count_reg + cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::MODE_POP_FRONT: begin
                    if (is_empty) begin
                        empty_next = 1'b1;
                    end else begin
                        ram_addr   = front_reg;
                        front_next = cdq_pkg::next_slot(front_reg);
                        hit_next   = 1'b1;
                        count_next = count_reg - cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::MODE_POP_BACK: begin
                    if (is_empty) begin
                        empty_next = 1'b1;
                    end else begin
                        ram_addr   = cdq_pkg::prev_slot(back_reg);
                        back_next  = cdq_pkg::prev_slot(back_reg);
                        hit_next   = 1'b1;
                        count_next = count_reg - cdq_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    ovf_next = 1'b0;
                end
            endcase
        end

        addr_next = ram_addr;

        if (load) begin
            m_valid_next             = 1'b1;
            m_data_next.popped_value = cur_popped;
            m_data_next.was_empty    = empty_reg;
            m_data_next.overflow     = ovf_reg;
            m_data_next.match        = cur_match;
            m_data_next.verdict_ok   = cur_verdict;
            m_data_next.occupancy    = cdq_pkg::OCC_W'(count_reg);
            m_data_next.batch_done   = last_reg;
            verdict_next             = cur_verdict;
            // The batch ends here: the next command starts on an empty deque.
            if (last_reg) begin
                front_next   = '0;
                back_next    = '0;
                count_next   = '0;
                verdict_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cdq_pkg::ST_IDLE;
            front_reg   <= '0;
            back_reg    <= '0;
            count_reg   <= '0;
            verdict_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            addr_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            count_reg   <= count_next;
            verdict_reg <= verdict_next;
            m_valid_reg <= m_valid_next;
            addr_reg    <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg    <= hit_next;
        empty_reg  <= empty_next;
        ovf_reg    <= ovf_next;
        last_reg   <= last_next;
        value_reg  <= value_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> dv/circular_deque_checker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_checker_core_tb
// Self-checking bench for the circular deque checker. Batches of push and pop
// commands are queued up front, sent with random gaps, and each result is
// compared with a cycle-free model of the deque that advances per transfer.
// ----------------------------------------------------------------------------
module circular_deque_checker_core_tb;

    localparam int GAP_MAX      = 18;
    localparam int RANDOM_ITEMS = 680;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 20;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    cdq_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    cdq_pkg::out_t m_data;

    circular_deque_checker_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Commands waiting to be sent, and results owed by the block.
    cdq_pkg::in_t  pending_cmds[$];
    cdq_pkg::out_t expected_results[$];
    int            fail_count = 0;

    // Contents of the deque as the command stream leaves it; used only to
    // pick expectations that hold, so that batches get deep.
    logic [cdq_pkg::ELEM_W-1:0] staged_contents[$];

    // Deque model, advanced once per accepted command.
    logic [cdq_pkg::ELEM_W-1:0] slot_model [cdq_pkg::CAPACITY];
    logic [cdq_pkg::IDX_W-1:0]  head_idx;
    logic [cdq_pkg::IDX_W-1:0]  tail_idx;
    logic                       full_seen;
    logic                       batch_ok;

    function automatic cdq_pkg::out_t apply_deque_cmd(input cdq_pkg::in_t cmd);
        cdq_pkg::out_t             r;
        logic [cdq_pkg::IDX_W-1:0] span;
        r = '0;
        r.match = 1'b1;
        if (cmd.mode == cdq_pkg::MODE_PUSH_FRONT || cmd.mode == cdq_pkg::MODE_PUSH_BACK) begin
            if (full_seen) begin
                r.overflow = 1'b1;
                batch_ok = 1'b0;
            end else if (cmd.mode == cdq_pkg::MODE_PUSH_FRONT) begin
                head_idx = head_idx - 1'b1;
                slot_model[head_idx] = cmd.value[cdq_pkg::ELEM_W-1:0];
                full_seen = (head_idx == tail_idx);
            end else begin
                slot_model[tail_idx] = cmd.value[cdq_pkg::ELEM_W-1:0];
                tail_idx = tail_idx + 1'b1;
                full_seen = (head_idx == tail_idx);
            end
        end else begin
            if (!full_seen && head_idx == tail_idx) begin
                r.was_empty = 1'b1;
                r.match = (cmd.value == cdq_pkg::EXPECT_EMPTY);
            end else begin
                if (cmd.mode == cdq_pkg::MODE_POP_FRONT) begin
                    r.popped_value = slot_model[head_idx];
                    head_idx = head_idx + 1'b1;
                end else begin
                    tail_idx = tail_idx - 1'b1;
                    r.popped_value = slot_model[tail_idx];
                end
                full_seen = 1'b0;
                r.match = (cmd.value == {1'b0, r.popped_value});
            end
            if (!r.match) begin
                batch_ok = 1'b0;
            end
        end
        span = tail_idx - head_idx;
        r.verdict_ok = batch_ok;
        r.occupancy = full_seen ? cdq_pkg::OCC_W'(cdq_pkg::CAPACITY) : cdq_pkg::OCC_W'(span);
        r.batch_done = cmd.last;
        if (cmd.last) begin
            head_idx = '0;
            tail_idx = '0;
            full_seen = 1'b0;
            batch_ok = 1'b1;
        end
        return r;
    endfunction

    task automatic queue_cmd(input cdq_pkg::mode_t mode,
                             input logic [cdq_pkg::VALUE_W-1:0] value,
                             input logic last);
        cdq_pkg::in_t cmd;
        cmd.mode = mode;
        cmd.value = value;
        cmd.last = last;
        pending_cmds.insert(pending_cmds.size(), cmd);
        case (mode)
            cdq_pkg::MODE_PUSH_FRONT: begin
                if (staged_contents.size() < cdq_pkg::CAPACITY) begin
                    staged_contents.insert(0, value[cdq_pkg::ELEM_W-1:0]);
                end
            end
            cdq_pkg::MODE_PUSH_BACK: begin
                if (staged_contents.size() < cdq_pkg::CAPACITY) begin
                    staged_contents.insert(staged_contents.size(),
                                           value[cdq_pkg::ELEM_W-1:0]);
                end
            end
            cdq_pkg::MODE_POP_FRONT: begin
                if (staged_contents.size() != 0) begin
                    staged_contents.delete(0);
                end
            end
            default: begin
                if (staged_contents.size() != 0) begin
                    staged_contents.delete(staged_contents.size() - 1);
                end
            end
        endcase
        if (last) begin
            staged_contents.delete();
        end
    endtask

    // A pop whose expectation holds unless honest is clear; dishonest ones cover
    // a random value, the empty value, negative values and a flipped bit 0.
    task automatic queue_pop(input cdq_pkg::mode_t mode, input logic last, input bit honest);
        logic [cdq_pkg::VALUE_W-1:0] want;
        if (staged_contents.size() == 0) begin
            want = cdq_pkg::EXPECT_EMPTY;
        end else if (mode == cdq_pkg::MODE_POP_FRONT) begin
            want = {1'b0, staged_contents[0]};
        end else begin
            want = {1'b0, staged_contents[$]};
        end
        if (!honest) begin
            case ($urandom_range(0, 3))
                0: want = $urandom;
                1: want = cdq_pkg::EXPECT_EMPTY;
                2: want = {1'b1, 31'($urandom)};
                default: want = want ^ 32'h1;
            endcase
        end
        queue_cmd(mode, want, last);
    endtask

    function automatic logic [cdq_pkg::VALUE_W-1:0] pick_element();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::mode_t pick_push();
        return $urandom_range(0, 1) ? cdq_pkg::MODE_PUSH_FRONT : cdq_pkg::MODE_PUSH_BACK;
    endfunction

    function automatic cdq_pkg::mode_t pick_pop();
        return $urandom_range(0, 1) ? cdq_pkg::MODE_POP_FRONT : cdq_pkg::MODE_POP_BACK;
    endfunction

    task automatic queue_random_batch(input int len);
        logic fin;
        for (int i = 0; i < len; i++) begin
            fin = (i == len - 1);
            if ($urandom_range(0, 99) < 55) begin
                queue_cmd(pick_push(), pick_element(), fin);
            end else begin
                queue_pop(pick_pop(), fin, $urandom_range(0, 99) < 85);
            end
        end
    endtask

    task automatic build_stimulus();
        int sent;
        int len;
        // Empty pops, extreme elements, every kind of failed expectation.
        queue_cmd(cdq_pkg::MODE_POP_FRONT, cdq_pkg::EXPECT_EMPTY, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_BACK, 32'd5, 1'b0);
        queue_cmd(cdq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
        queue_cmd(cdq_pkg::MODE_PUSH_BACK, 32'h0000_0000, 1'b0);
        queue_cmd(cdq_pkg::MODE_PUSH_BACK, 32'h8000_0000, 1'b0);
        queue_cmd(cdq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_FRONT, 32'h7FFF_FFFF, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_BACK, 32'h0000_0000, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_BACK, cdq_pkg::EXPECT_EMPTY, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_FRONT, 32'h8000_0001, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_FRONT, cdq_pkg::EXPECT_EMPTY, 1'b1);
        // A clean batch, so the verdict holds to the end.
        queue_cmd(cdq_pkg::MODE_PUSH_BACK, 32'd1, 1'b0);
        queue_cmd(cdq_pkg::MODE_PUSH_FRONT, 32'd2, 1'b0);
        queue_cmd(cdq_pkg::MODE_PUSH_BACK, 32'h5555_5555, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_BACK, 32'h5555_5555, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_BACK, 32'd1, 1'b0);
        queue_cmd(cdq_pkg::MODE_POP_FRONT, 32'd2, 1'b1);
        // Single-command batches; the last one shows the deque was cleared.
        queue_cmd(cdq_pkg::MODE_POP_BACK, cdq_pkg::EXPECT_EMPTY, 1'b1);
        queue_cmd(cdq_pkg::MODE_PUSH_BACK, 32'h2AAA_AAAA, 1'b1);
        queue_cmd(cdq_pkg::MODE_PUSH_FRONT, 32'h1234_5678, 1'b1);
        queue_cmd(cdq_pkg::MODE_POP_BACK, cdq_pkg::EXPECT_EMPTY, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                              : $urandom_range(1, 40);
            if (len > RANDOM_ITEMS - sent) begin
                len = RANDOM_ITEMS - sent;
            end
            queue_random_batch(len);
            sent += len;
        end
    endtask

    // Sender: one gap per command, with stretches of back-to-back transfers.
    int   tx_gap;
    bit   tx_burst;
    int   accepted_cmds;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            accepted_cmds <= 0;
            tx_gap = 0;
            tx_burst = 1'b0;
            head_idx = '0;
            tail_idx = '0;
            full_seen = 1'b0;
            batch_ok = 1'b1;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), apply_deque_cmd(s_data));
                accepted_cmds <= accepted_cmds + 1;
                if ($urandom_range(0, 39) == 0) begin
                    tx_burst = !tx_burst;
                end
                tx_gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap == 0 && pending_cmds.size() != 0) begin
                    s_data <= pending_cmds[0];
                    pending_cmds.delete(0);
                    s_valid <= 1'b1;
                end else begin
                    if (tx_gap != 0) begin
                        tx_gap--;
                    end
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long stall of the result side, which holds back the command side too.
    logic hold_off = 1'b0;
    bit   hold_done;
    int   hold_cycles;

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_off <= 1'b0;
            hold_done <= 1'b0;
            hold_cycles <= 0;
        end else if (!hold_done && !hold_off && accepted_cmds >= HOLD_AT) begin
            hold_off <= 1'b1;
            hold_cycles <= HOLD_LEN;
        end else if (hold_off) begin
            if (hold_cycles == 1) begin
                hold_off <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_cycles <= hold_cycles - 1;
        end
    end

    task automatic check_result(input cdq_pkg::out_t got, input cdq_pkg::out_t want);
        if (got.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0h, got %0h", want.popped_value, got.popped_value);
            fail_count++;
        end
        if (got.was_empty !== want.was_empty) begin
            $error("was_empty: expected %0b, got %0b", want.was_empty, got.was_empty);
            fail_count++;
        end
        if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            fail_count++;
        end
        if (got.match !== want.match) begin
            $error("match: expected %0b, got %0b", want.match, got.match);
            fail_count++;
        end
        if (got.verdict_ok !== want.verdict_ok) begin
            $error("verdict_ok: expected %0b, got %0b", want.verdict_ok, got.verdict_ok);
            fail_count++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            fail_count++;
        end
        if (got.batch_done !== want.batch_done) begin
            $error("batch_done: expected %0b, got %0b", want.batch_done, got.batch_done);
            fail_count++;
        end
    endtask

    // Receiver: after each transfer ready drops for a random wait, which may be zero.
    int rx_wait;
    bit rx_burst;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
            rx_burst = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding: %p", m_data);
                    fail_count++;
                end else begin
                    check_result(m_data, expected_results[0]);
                    expected_results.delete(0);
                end
                if ($urandom_range(0, 39) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0) && !hold_off;
        end
    end

    initial begin
        build_stimulus();
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        while (pending_cmds.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("circular_deque_checker_core_tb: PASS");
        end else begin
            $display("circular_deque_checker_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("circular_deque_checker_core_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque_checker_core.sv
dv/circular_deque_checker_core_tb.sv
